@@ design/bpe_pkg.sv @@
// bezier point evaluator package: widths, register indexes and cell control type
// used by bpe_cell and the top level; no dependencies
package bpe_pkg;

  localparam int MAX_POINTS = 5;
  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 10;
  localparam int POINT_REGS = 5;

  localparam int STAGES = MAX_POINTS - 1;
  localparam int POS_W  = COORD_BITS + FRAC_BITS;
  localparam int PT_W   = 2 * COORD_BITS;
  localparam int T_W    = FRAC_BITS + 1;
  localparam int CNT_W  = 3;
  localparam int IDX_W  = 3;
  localparam int N_W    = $clog2(MAX_POINTS + 1) + 1;

  localparam int S_TDATA_W = ((T_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((2 * POS_W + 7) / 8) * 8;

  localparam logic [T_W-1:0]   T_ONE       = T_W'(1) << FRAC_BITS;
  localparam logic [IDX_W-1:0] COUNT_IDX   = IDX_W'(5);
  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(5);
  localparam logic [N_W-1:0]   N_MIN       = N_W'(2);
  localparam logic [N_W-1:0]   N_MAX       = N_W'(MAX_POINTS);

  typedef struct packed {
    logic en;
    logic pass;
  } cell_ctl_t;

endpackage

@@ design/bpe_cell.sv @@
// one interpolation cell of the de casteljau chain: p + floor((q - p) * t)
// depends on bpe_pkg
module bpe_cell (
  input  logic                     clk_i,
  input  bpe_pkg::cell_ctl_t       ctl_i,
  input  logic [bpe_pkg::POS_W-1:0] p_i,
  input  logic [bpe_pkg::POS_W-1:0] q_i,
  input  logic [bpe_pkg::T_W-1:0]   t_i,
  output logic [bpe_pkg::POS_W-1:0] r_o
);
  import bpe_pkg::*;

  localparam int PROD_W = POS_W + T_W + 2;

  logic signed [POS_W:0]    diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] part;
  logic signed [PROD_W-1:0] sum;
  logic [POS_W-1:0]         r_d;
  logic [POS_W-1:0]         r_q;

  always_comb begin
    diff = $signed({1'b0, q_i}) - $signed({1'b0, p_i});
    prod = PROD_W'(diff) * $signed({{(PROD_W - T_W){1'b0}}, t_i});
    part = prod >>> FRAC_BITS;
    sum  = $signed({{(PROD_W - POS_W){1'b0}}, p_i}) + part;
    r_d  = ctl_i.pass ? p_i : sum[POS_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      r_q <= r_d;
    end
  end

  assign r_o = r_q;

endmodule

@@ design/bezier_point_evaluator.sv @@
// bezier point evaluator top level: config registers, valid chain and cell rows
// depends on bpe_pkg and bpe_cell
//
// Each transfer on the slave side carries t in Q1.10 (values above 1.0 act as 1.0)
// and yields one curve point on the master side, x and y in Q10.10, from the
// control points and point count last written on the config port. The block takes
// one item per cycle unless the master side stalls; each result passes one row of
// interpolation cells per de casteljau level, each cell one multiply and add into a
// register, with MAX_POINTS-1 rows. Curves with fewer points pass through the leading
// rows unchanged, so latency does not depend on the point count. A stage takes a new
// item whenever it is empty or its successor moves, so bubbles fill while a result
// waits. The user must write config only while no item is in flight (not enforced).
module bezier_point_evaluator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpe_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [bpe_pkg::PT_W-1:0]      cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // t_param
  input  logic [bpe_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // x_pos, y_pos
  output logic [bpe_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import bpe_pkg::*;

  logic [PT_W-1:0]  point_q [MAX_POINTS];
  logic [CNT_W-1:0] count_q;
  logic [N_W-1:0]   n_pts;

  logic [STAGES-1:0] valid_q;
  logic [STAGES-1:0] stage_en;
  logic [STAGES-1:0] active;
  logic [T_W-1:0]    t_q [STAGES];
  logic [T_W-1:0]    t_in;

  logic [POS_W-1:0] in_x  [STAGES][MAX_POINTS];
  logic [POS_W-1:0] in_y  [STAGES][MAX_POINTS];
  logic [POS_W-1:0] out_x [STAGES][MAX_POINTS];
  logic [POS_W-1:0] out_y [STAGES][MAX_POINTS];

  // config registers
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_pt
    if (k < POINT_REGS) begin : g_reg
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          point_q[k] <= '0;
        end else if (cfg_we_i && cfg_idx_i == IDX_W'(k)) begin
          point_q[k] <= cfg_data_i;
        end
      end
    end else begin : g_zero
      assign point_q[k] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else if (cfg_we_i && cfg_idx_i == COUNT_IDX) begin
      count_q <= cfg_data_i[CNT_W-1:0];
    end
  end

  always_comb begin
    n_pts = N_W'(count_q);
    if (n_pts < N_MIN) begin
      n_pts = N_MIN;
    end
    if (n_pts > N_MAX) begin
      n_pts = N_MAX;
    end
  end

  // t saturation at the input
  always_comb begin
    t_in = s_axis_tdata[T_W-1:0];
    if (t_in > T_ONE) begin
      t_in = T_ONE;
    end
  end

  // stage enables, from the output back
  always_comb begin
    stage_en[STAGES-1] = !valid_q[STAGES-1] || m_axis_tready;
    for (int s = STAGES - 2; s >= 0; s--) begin
      stage_en[s] = !valid_q[s] || stage_en[s+1];
    end
  end

  assign s_axis_tready = stage_en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[0]) begin
        valid_q[0] <= s_axis_tvalid;
      end
      for (int s = 1; s < STAGES; s++) begin
        if (stage_en[s]) begin
          valid_q[s] <= valid_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      t_q[0] <= t_in;
    end
    for (int s = 1; s < STAGES; s++) begin
      if (stage_en[s]) begin
        t_q[s] <= t_q[s-1];
      end
    end
  end

  // cell rows, leading rows pass through for shorter curves
  for (genvar s = 0; s < STAGES; s++) begin : g_row
    assign active[s] = (n_pts + N_W'(s)) >= N_MAX;

    for (genvar j = 0; j < MAX_POINTS; j++) begin : g_in
      if (s == 0) begin : g_src
        assign in_x[s][j] = {point_q[j][COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
        assign in_y[s][j] = {point_q[j][PT_W-1:COORD_BITS], {FRAC_BITS{1'b0}}};
      end else begin : g_prev
        assign in_x[s][j] = out_x[s-1][j];
        assign in_y[s][j] = out_y[s-1][j];
      end
    end

    for (genvar j = 0; j < MAX_POINTS; j++) begin : g_cell
      if (j < MAX_POINTS - 1 - s) begin : g_live
        cell_ctl_t ctl;
        logic [T_W-1:0] t_cell;

        assign ctl.en   = stage_en[s];
        assign ctl.pass = !active[s];

        if (s == 0) begin : g_t0
          assign t_cell = t_in;
        end else begin : g_tn
          assign t_cell = t_q[s-1];
        end

        bpe_cell u_cell_x (
          .clk_i (clk_i),
          .ctl_i (ctl),
          .p_i   (in_x[s][j]),
          .q_i   (in_x[s][j+1]),
          .t_i   (t_cell),
          .r_o   (out_x[s][j])
        );

        bpe_cell u_cell_y (
          .clk_i (clk_i),
          .ctl_i (ctl),
          .p_i   (in_y[s][j]),
          .q_i   (in_y[s][j+1]),
          .t_i   (t_cell),
          .r_o   (out_y[s][j])
        );
      end else begin : g_none
        assign out_x[s][j] = '0;
        assign out_y[s][j] = '0;
      end
    end
  end

  assign m_axis_tvalid = valid_q[STAGES-1];
  assign m_axis_tdata  = M_TDATA_W'({out_y[STAGES-1][0], out_x[STAGES-1][0]});

endmodule
